[hw/rtl/skt_pkg.sv]
package skt_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] stock;
    logic        [31:0] price;
    logic signed [31:0] key;
  } rec_t;

  localparam int unsigned RANK_W = 7;
  localparam int unsigned DATA_W = 104;

endpackage

[hw/rtl/sorted_key_table_core.sv]
// Sorted record table: up to TABLE_DEPTH records (key, price word, stock)
// kept in ascending signed key order in a single-port-write, single-port-read
// memory with a registered read port. Each command beat on in_* gives
// exactly one result beat on out_*; commands are taken one at a time and a
// finished result waits in the output register while the next command is
// accepted. Insert and delete move one entry per cycle through the memory.
// Insert keeps equal keys in arrival order and reports table full when no room
// is left; delete removes the lowest-ranked matching key; read takes a 1-based
// rank. Data fields of a result are zero for all but a successful read.
module sorted_key_table_core
  import skt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // key [31:0], price_word [63:32], stock_in [95:64], rank [102:96]
  input  logic [DATA_W-1:0] in_tdata,
  // command [1:0]
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // key_out [31:0], price_out [63:32], stock_out [95:64], entry_count [102:96]
  output logic [DATA_W-1:0] out_tdata,
  // status [1:0]
  output logic [1:0]        out_tuser
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RW = (CW > RANK_W) ? CW : RANK_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_LAST,
    S_DEL_SCAN,
    S_DEL_SHIFT,
    S_RD_WAIT,
    S_RESP
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  rec_t            new_r, new_nxt;
  status_t         res_status_r, res_status_nxt;
  rec_t            res_rec_r, res_rec_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  rec_t            out_rec_r, out_rec_nxt;
  logic [RANK_W-1:0] out_count_r, out_count_nxt;

  rec_t            mem [TABLE_DEPTH];
  rec_t            rd_q;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  rec_t            wr_data;

  rec_t            in_rec;
  cmd_t            in_cmd;
  logic [RW-1:0]   rank_ext;
  logic [RW-1:0]   rank_m1;
  logic [CW-1:0]   count_m1;
  logic [CW-1:0]   ptr_m1, ptr_m2, ptr_p1, ptr_p2;
  logic            in_fire;
  logic            out_free;

  assign in_rec.key   = in_tdata[31:0];
  assign in_rec.price = in_tdata[63:32];
  assign in_rec.stock = in_tdata[95:64];
  assign in_cmd       = cmd_t'(in_tuser);
  assign rank_ext     = RW'(in_tdata[102:96]);
  assign rank_m1      = rank_ext - RW'(1);
  assign count_m1     = count_r - CW'(1);
  assign ptr_m1       = ptr_r - CW'(1);
  assign ptr_m2       = ptr_r - CW'(2);
  assign ptr_p1       = ptr_r + CW'(1);
  assign ptr_p2       = ptr_r + CW'(2);

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_count_r, out_rec_r.stock, out_rec_r.price, out_rec_r.key};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = new_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          new_nxt        = in_rec;
          res_status_nxt = ST_OK;
          res_rec_nxt    = '0;
          state_nxt      = S_RESP;
          case (in_cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_INSERT: begin
              if (count_r >= CW'(TABLE_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = in_rec;
                count_nxt = CW'(1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = count_m1[AW-1:0];
                ptr_nxt   = count_r;
                state_nxt = S_INS_SCAN;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = S_DEL_SCAN;
              end
            end
            CMD_READ: begin
              if (rank_ext == '0 || rank_ext > RW'(count_r)) begin
                res_status_nxt = ST_RANGE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = rank_m1[AW-1:0];
                state_nxt = S_RD_WAIT;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // rd_q holds entry ptr-1; shift it up while the new key sorts below it
      S_INS_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        if (new_r.key < rd_q.key) begin
          wr_data = rd_q;
          if (ptr_r == CW'(1)) begin
            state_nxt = S_INS_LAST;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_m2[AW-1:0];
            ptr_nxt = ptr_m1;
          end
        end else begin
          wr_data   = new_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_INS_LAST: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = new_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESP;
      end

      // rd_q holds entry ptr
      S_DEL_SCAN: begin
        if (rd_q.key == new_r.key) begin
          if (ptr_p1 >= count_r) begin
            count_nxt = count_m1;
            state_nxt = S_RESP;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ptr_p1[AW-1:0];
            state_nxt = S_DEL_SHIFT;
          end
        end else if (ptr_p1 >= count_r) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_p1[AW-1:0];
          ptr_nxt = ptr_p1;
        end
      end

      // rd_q holds entry ptr+1, moved down to ptr
      S_DEL_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        wr_data = rd_q;
        if (ptr_p2 >= count_r) begin
          count_nxt = count_m1;
          state_nxt = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_p2[AW-1:0];
          ptr_nxt = ptr_p1;
        end
      end

      S_RD_WAIT: begin
        res_rec_nxt = rd_q;
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rec_nxt    = res_rec_r;
          out_count_nxt  = RANK_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r        <= ptr_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_count_r  <= out_count_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == CMD_CLEAR) |=> count_r == '0)
    else $error("clear did not empty the table");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_free && res_status_r == ST_FULL)
      |-> count_r == CW'(TABLE_DEPTH))
    else $error("table full reported with room left");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd != CMD_CLEAR) |=> !in_tready)
    else $error("command accepted while another is in work");
`endif

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  localparam int DEPTH = 64;

  typedef struct packed {
    status_t     st;
    logic [31:0] key;
    logic [31:0] price;
    logic [31:0] stock;
    logic [6:0]  cnt;
  } table_result_t;

  typedef struct packed {
    cmd_t          cmd;
    logic [31:0]   key;
    logic [31:0]   price;
    logic [31:0]   stock;
    logic [6:0]    rank;
    logic          typed;
    table_result_t want;
  } dir_row_t;

  typedef enum int {MIX_PACK, MIX_GROW, MIX_SHRINK, MIX_EVEN} traffic_t;

  localparam table_result_t NO_RES = '{ST_OK, 32'h0, 32'h0, 32'h0, 7'd0};

  localparam dir_row_t DIRECTED_ROWS[24] = '{
    '{CMD_READ,   32'h0, 32'h0, 32'h0, 7'd1, 1'b1, '{ST_RANGE, 32'h0, 32'h0, 32'h0, 7'd0}},
    '{CMD_READ,   32'h0, 32'h0, 32'h0, 7'd0, 1'b1, '{ST_RANGE, 32'h0, 32'h0, 32'h0, 7'd0}},
    '{CMD_DELETE, 32'd5, 32'h0, 32'h0, 7'd0, 1'b1,
      '{ST_NOT_FOUND, 32'h0, 32'h0, 32'h0, 7'd0}},
    '{CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 7'd0, 1'b1,
      '{ST_OK, 32'h0, 32'h0, 32'h0, 7'd1}},
    '{CMD_INSERT, 32'h8000_0000, 32'h0, 32'h8000_0000, 7'd0, 1'b1,
      '{ST_OK, 32'h0, 32'h0, 32'h0, 7'd2}},
    '{CMD_INSERT, 32'h0, 32'h1234_5678, 32'hffff_ffff, 7'd0, 1'b0, NO_RES},
    '{CMD_INSERT, 32'h0, 32'ha5a5_a5a5, 32'h0000_0001, 7'd0, 1'b0, NO_RES},
    '{CMD_INSERT, 32'hffff_ffff, 32'h5a5a_5a5a, 32'h0000_1000, 7'd0, 1'b0, NO_RES},
    '{CMD_READ,   32'h0, 32'h0, 32'h0, 7'd1, 1'b1,
      '{ST_OK, 32'h8000_0000, 32'h0, 32'h8000_0000, 7'd5}},
    '{CMD_READ,   32'h0, 32'h0, 32'h0, 7'd5, 1'b1,
      '{ST_OK, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 7'd5}},
    '{CMD_READ,   32'h0, 32'h0, 32'h0, 7'd3, 1'b0, NO_RES},
    '{CMD_READ,   32'h0, 32'h0, 32'h0, 7'd4, 1'b0, NO_RES},
    '{CMD_READ,   32'h0, 32'h0, 32'h0, 7'd6, 1'b1, '{ST_RANGE, 32'h0, 32'h0, 32'h0, 7'd5}},
    '{CMD_READ,   32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 7'd127, 1'b1,
      '{ST_RANGE, 32'h0, 32'h0, 32'h0, 7'd5}},
    '{CMD_DELETE, 32'h0, 32'h0, 32'h0, 7'd0, 1'b0, NO_RES},
    '{CMD_READ,   32'h0, 32'h0, 32'h0, 7'd3, 1'b0, NO_RES},
    '{CMD_DELETE, 32'h7fff_ffff, 32'h0, 32'h0, 7'd0, 1'b0, NO_RES},
    '{CMD_DELETE, 32'd12345, 32'h0, 32'h0, 7'd0, 1'b1,
      '{ST_NOT_FOUND, 32'h0, 32'h0, 32'h0, 7'd3}},
    '{CMD_INSERT, 32'd77, 32'hdead_beef, 32'hffff_ff00, 7'd127, 1'b0, NO_RES},
    '{CMD_DELETE, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 7'd64, 1'b0, NO_RES},
    '{CMD_CLEAR,  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 7'd127, 1'b1,
      '{ST_OK, 32'h0, 32'h0, 32'h0, 7'd0}},
    '{CMD_READ,   32'h0, 32'h0, 32'h0, 7'd1, 1'b1, '{ST_RANGE, 32'h0, 32'h0, 32'h0, 7'd0}},
    '{CMD_INSERT, 32'h8000_0000, 32'h0bad_f00d, 32'h0000_0042, 7'd0, 1'b0, NO_RES},
    '{CMD_READ,   32'h0, 32'h0, 32'h0, 7'd64, 1'b1, '{ST_RANGE, 32'h0, 32'h0, 32'h0, 7'd1}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata = '0;
  logic [1:0]          in_tuser = CMD_CLEAR;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;
  logic [1:0]          out_tuser;

  logic [31:0]         held_key[DEPTH];
  logic [31:0]         held_price[DEPTH];
  logic [31:0]         held_stock[DEPTH];
  int                  fill_n = 0;

  table_result_t       pending_results[$];
  int                  errors = 0;
  int                  beats_sent = 0;
  int                  results_seen = 0;

  always #10 clk = ~clk;

  sorted_key_table_core #(.TABLE_DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // sorted table: apply one command and return its result
  function automatic table_result_t table_apply(cmd_t cmd, logic [31:0] key,
                                                logic [31:0] price, logic [31:0] stock,
                                                logic [6:0] rank);
    table_result_t res;
    int            pos;
    int            i;
    res.st    = ST_OK;
    res.key   = '0;
    res.price = '0;
    res.stock = '0;
    case (cmd)
      CMD_CLEAR: begin
        fill_n = 0;
      end
      CMD_INSERT: begin
        if (fill_n >= DEPTH) begin
          res.st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < fill_n && !($signed(key) < $signed(held_key[pos]))) pos++;
          for (i = fill_n; i > pos; i--) begin
            held_key[i]   = held_key[i-1];
            held_price[i] = held_price[i-1];
            held_stock[i] = held_stock[i-1];
          end
          held_key[pos]   = key;
          held_price[pos] = price;
          held_stock[pos] = stock;
          fill_n++;
        end
      end
      CMD_DELETE: begin
        pos = 0;
        while (pos < fill_n && held_key[pos] != key) pos++;
        if (pos >= fill_n) begin
          res.st = ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < fill_n; i++) begin
            held_key[i]   = held_key[i+1];
            held_price[i] = held_price[i+1];
            held_stock[i] = held_stock[i+1];
          end
          fill_n--;
        end
      end
      default: begin
        if (rank == 0 || int'(rank) > fill_n) begin
          res.st = ST_RANGE;
        end else begin
          res.key   = held_key[rank-1];
          res.price = held_price[rank-1];
          res.stock = held_stock[rank-1];
        end
      end
    endcase
    res.cnt = fill_n[6:0];
    return res;
  endfunction

  function automatic logic [31:0] draw_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 15) - 32'd8;
    if (r < 85) return $urandom;
    if (r < 92) return 32'h8000_0000;
    return 32'h7fff_ffff;
  endfunction

  function automatic logic [6:0] draw_rank();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70 && fill_n > 0) return 7'($urandom_range(1, fill_n));
    if (r < 80) return 7'd0;
    if (r < 90) return 7'(fill_n + 1);
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic cmd_t draw_cmd(traffic_t mix);
    int unsigned r;
    int          ins_w;
    int          del_w;
    int          rd_w;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_PACK:   begin ins_w = 95; del_w = 0;  rd_w = 5;  end
      MIX_GROW:   begin ins_w = 80; del_w = 8;  rd_w = 11; end
      MIX_SHRINK: begin ins_w = 15; del_w = 60; rd_w = 24; end
      default:    begin ins_w = 40; del_w = 35; rd_w = 22; end
    endcase
    if (r < ins_w) return CMD_INSERT;
    if (r < ins_w + del_w) return CMD_DELETE;
    if (r < ins_w + del_w + rd_w) return CMD_READ;
    return CMD_CLEAR;
  endfunction

  // one command beat; the result is typed in or predicted at acceptance
  task automatic offer_command(cmd_t cmd, logic [31:0] key, logic [31:0] price,
                               logic [31:0] stock, logic [6:0] rank,
                               logic typed, table_result_t want);
    table_result_t predicted;
    while (!(beats_sent >= 260 && beats_sent < 340) && $urandom_range(0, 99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, rank, stock, price, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = table_apply(cmd, key, price, stock, rank);
    pending_results.push_back(typed ? want : predicted);
    beats_sent++;
  endtask

  task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic take_result();
    table_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing pending, expected none, got %h/%h",
               $time, out_tuser, out_tdata);
      errors++;
    end else begin
      want = pending_results.pop_front();
      compare_field("status", 32'(want.st), 32'(out_tuser));
      compare_field("key_out", want.key, out_tdata[31:0]);
      compare_field("price_out", want.price, out_tdata[63:32]);
      compare_field("stock_out", want.stock, out_tdata[95:64]);
      compare_field("entry_count", 32'(want.cnt), 32'(out_tdata[102:96]));
    end
    results_seen++;
  endtask

  initial begin : result_sink
    int  hold;
    logic pressure_done;
    pressure_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) take_result();
      if (!pressure_done && results_seen == 120) begin
        pressure_done = 1'b1;
        out_tready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end
      out_tready <= (results_seen >= 330 && results_seen < 410) ||
                    ($urandom_range(0, 99) >= 24);
    end
  end

  initial begin : command_source
    int          idx;
    int          n;
    int          seg_len;
    int          random_items;
    traffic_t    mix;
    cmd_t        cmd;
    logic [31:0] key;
    logic [6:0]  rank;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (idx = 0; idx < 24; idx++)
      offer_command(DIRECTED_ROWS[idx].cmd, DIRECTED_ROWS[idx].key,
                    DIRECTED_ROWS[idx].price, DIRECTED_ROWS[idx].stock,
                    DIRECTED_ROWS[idx].rank, DIRECTED_ROWS[idx].typed,
                    DIRECTED_ROWS[idx].want);

    // first segment packs the table past full
    random_items = 0;
    mix = MIX_PACK;
    seg_len = 90;
    while (random_items < 500) begin
      for (n = 0; n < seg_len && random_items < 500; n++) begin
        cmd  = draw_cmd(mix);
        key  = draw_key();
        rank = draw_rank();
        if (cmd == CMD_DELETE && fill_n > 0 && $urandom_range(0, 99) < 70)
          key = held_key[$urandom_range(0, fill_n - 1)];
        offer_command(cmd, key, $urandom, $urandom, rank, 1'b0, NO_RES);
        random_items++;
      end
      mix = traffic_t'($urandom_range(1, 3));
      seg_len = $urandom_range(20, 60);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
